FILE: rtl/btc_pkg.sv
`timescale 1ns / 1ps

package btc_pkg;

  // Largest block the buffers can hold, and the matching index width.
  localparam int unsigned MaxBlock = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CntW     = 5;

  localparam logic [7:0] PAD_BYTE = 8'h20;

  // Configuration register indexes.
  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
  localparam logic [1:0] REG_PERM_TABLE   = 2'd1;
  localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

  // Byte write from the front end into the bank being filled.
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [7:0]      data;
    logic            close;   // this byte completes the block
    logic [CntW-1:0] count;   // bytes held once this byte is stored
  } btc_wr_t;

  // Read request from the back end into the bank being drained.
  typedef struct packed {
    logic [IdxW-1:0] addr;
    logic            pop;     // last byte of the block has been taken
  } btc_rq_t;

  // Bank status and read data toward the back end.
  typedef struct packed {
    logic            full;
    logic [7:0]      data;
    logic [CntW-1:0] count;
  } btc_rd_t;

  // Block length as used by the datapath: zero counts as one, above MaxBlock clamps.
  function automatic logic [CntW-1:0] eff_length(input logic [CntW-1:0] raw);
    logic [CntW-1:0] n;
    n = raw;
    if (n == '0) begin
      n = CntW'(1);
    end
    if (n > CntW'(MaxBlock)) begin
      n = CntW'(MaxBlock);
    end
    return n;
  endfunction

endpackage

FILE: rtl/btc_front.sv
`timescale 1ns / 1ps

module btc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [7:0]                 data_byte,
  input  logic                       end_of_message,
  input  logic [btc_pkg::CntW-1:0]   len,
  output btc_pkg::btc_wr_t           wr
);

  logic [btc_pkg::CntW-1:0] fill_r, fill_nxt;
  logic [btc_pkg::CntW-1:0] new_fill;
  logic                     room;
  logic                     close;

  // A full buffer drops the byte without counting it; the full count then closes the block.
  assign room     = fill_r < btc_pkg::CntW'(btc_pkg::MaxBlock);
  assign new_fill = room ? fill_r + btc_pkg::CntW'(1) : fill_r;
  assign close    = (new_fill >= len) || end_of_message;

  always_comb begin
    wr.en    = in_fire && room;
    wr.addr  = fill_r[btc_pkg::IdxW-1:0];
    wr.data  = data_byte;
    wr.close = in_fire && close;
    wr.count = new_fill;
    fill_nxt = fill_r;
    if (in_fire) begin
      fill_nxt = close ? '0 : new_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

FILE: rtl/btc_queue.sv
`timescale 1ns / 1ps

module btc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  btc_pkg::btc_wr_t wr,
  input  btc_pkg::btc_rq_t rq,
  output logic             wr_ready,
  output btc_pkg::btc_rd_t rd
);

  logic [7:0]               bank0_r [btc_pkg::MaxBlock];
  logic [7:0]               bank1_r [btc_pkg::MaxBlock];
  logic [btc_pkg::CntW-1:0] count_r [2];
  logic [1:0]               full_r, full_nxt;
  logic                     wsel_r, wsel_nxt;
  logic                     rsel_r, rsel_nxt;

  assign wr_ready = !full_r[wsel_r];

  always_comb begin
    rd.full  = full_r[rsel_r];
    rd.data  = rsel_r ? bank1_r[rq.addr] : bank0_r[rq.addr];
    rd.count = count_r[rsel_r];
  end

  always_comb begin
    full_nxt = full_r;
    wsel_nxt = wsel_r;
    rsel_nxt = rsel_r;
    if (wr.close) begin
      full_nxt[wsel_r] = 1'b1;
      wsel_nxt         = !wsel_r;
    end
    if (rq.pop) begin
      full_nxt[rsel_r] = 1'b0;
      rsel_nxt         = !rsel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
      wsel_r <= 1'b0;
      rsel_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
      wsel_r <= wsel_nxt;
      rsel_r <= rsel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && !wsel_r) begin
      bank0_r[wr.addr] <= wr.data;
    end
    if (wr.en && wsel_r) begin
      bank1_r[wr.addr] <= wr.data;
    end
    if (wr.close) begin
      count_r[wsel_r] <= wr.count;
    end
  end

endmodule

FILE: rtl/btc_back.sv
`timescale 1ns / 1ps

module btc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [btc_pkg::CntW-1:0] len,
  input  logic [63:0]              perm,
  input  logic                     decrypt,
  input  btc_pkg::btc_rd_t         rd,
  output btc_pkg::btc_rq_t         rq,
  output logic                     out_valid,
  output logic [7:0]               out_byte,
  output logic                     out_last,
  input  logic                     out_ready
);

  logic [btc_pkg::IdxW-1:0] pos_r, pos_nxt;
  logic                     valid_r, valid_nxt;
  logic [7:0]               byte_r, byte_nxt;
  logic                     last_r, last_nxt;

  logic                     advance;
  logic                     is_last;
  logic [btc_pkg::IdxW-1:0] src;
  logic                     found;
  logic [btc_pkg::IdxW-1:0] jsel;
  logic                     hit;

  assign advance = rd.full && (!valid_r || out_ready);
  assign is_last = pos_r == btc_pkg::IdxW'(len - btc_pkg::CntW'(1));
  assign src     = perm[pos_r*btc_pkg::IdxW +: btc_pkg::IdxW];

  // Decrypt: find the highest source slot within the block that scatters to this position.
  always_comb begin
    found = 1'b0;
    jsel  = '0;
    for (int j = 0; j < btc_pkg::MaxBlock; j++) begin
      if ((btc_pkg::CntW'(j) < len) &&
          (perm[j*btc_pkg::IdxW +: btc_pkg::IdxW] == pos_r)) begin
        found = 1'b1;
        jsel  = btc_pkg::IdxW'(j);
      end
    end
  end

  // Slots at or above the stored count read as padding.
  always_comb begin
    if (decrypt) begin
      rq.addr = jsel;
      hit     = found && ({1'b0, jsel} < rd.count);
    end else begin
      rq.addr = src;
      hit     = {1'b0, src} < rd.count;
    end
    rq.pop = advance && is_last;
  end

  always_comb begin
    pos_nxt   = pos_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (advance) begin
      valid_nxt = 1'b1;
      byte_nxt  = hit ? rd.data : btc_pkg::PAD_BYTE;
      last_nxt  = is_last;
      pos_nxt   = is_last ? '0 : pos_r + btc_pkg::IdxW'(1);
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

FILE: rtl/block_transposition_cipher_unit.sv
`timescale 1ns / 1ps

// Block transposition cipher. Bytes arrive on the in_ stream and are gathered into blocks of
// block_length bytes (0 counts as 1, values above 16 count as 16). A block closes when it is
// full or when an item arrives with tlast set; a short block is padded with spaces. Each
// closed block leaves on the out_ stream as block_length items, permuted by perm_table
// (entry j in bits 4j+3..4j): in encrypt mode output j is stored byte perm[j], in decrypt
// mode stored byte j goes to output perm[j], later entries winning a collision and unhit
// positions carrying a space. tlast marks the final item of each block. Two block buffers
// alternate: the front fills one while the back drains the other, so input is taken one
// item per cycle until both buffers hold closed blocks. The back emits one item per cycle
// while out_tready is high; without stalls or blocks closed early, both sides run at one
// item per cycle. Configuration must be written only while no block is pending output;
// software must load a valid permutation of 0..block_length-1.

module block_transposition_cipher_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_message

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast   // last_of_block
);

  logic [btc_pkg::CntW-1:0] block_length_r;
  logic [63:0]              perm_table_r;
  logic                     decrypt_mode_r;
  logic [btc_pkg::CntW-1:0] len;
  logic                     in_fire;

  btc_pkg::btc_wr_t wr;
  btc_pkg::btc_rq_t rq;
  btc_pkg::btc_rd_t rd;

  // Configuration registers; a write to an unused index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r <= btc_pkg::CntW'(btc_pkg::MaxBlock);
      perm_table_r   <= '0;
      decrypt_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        btc_pkg::REG_BLOCK_LENGTH: block_length_r <= cfg_wdata[btc_pkg::CntW-1:0];
        btc_pkg::REG_PERM_TABLE:   perm_table_r   <= cfg_wdata;
        btc_pkg::REG_DECRYPT_MODE: decrypt_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign len     = btc_pkg::eff_length(block_length_r);
  assign in_fire = in_tvalid && in_tready;

  // Front end: counts bytes into the open buffer and decides when the block closes.
  btc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .data_byte      (in_tdata),
    .end_of_message (in_tlast),
    .len            (len),
    .wr             (wr)
  );

  // Two block buffers between the front and back ends.
  btc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rq       (rq),
    .wr_ready (in_tready),
    .rd       (rd)
  );

  // Back end: walks the output positions of a closed block through the permutation.
  btc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .len       (len),
    .perm      (perm_table_r),
    .decrypt   (decrypt_mode_r),
    .rd        (rd),
    .rq        (rq),
    .out_valid (out_tvalid),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

endmodule

FILE: verif/tb_block_transposition_cipher_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the block transposition cipher. A directed table runs first, then
// random phases that each load a fresh configuration and stream bytes through the unit. Every
// accepted input item is run through a local model of the cipher. The bytes that the model
// predicts, or a pinned row gives, are queued and matched in order against the out_ stream.
module tb_block_transposition_cipher_unit;

  // Index with no register behind it; writes there must leave the unit unchanged.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Random items after the directed table; together they come to about 480 input items.
  localparam int unsigned RANDOM_ITEMS = 460;
  // Cycles to wait after the last expected byte, so a byte that only fills a buffer has
  // landed before the configuration moves under it.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES  = 40;
  // Worst case is about 500 items, each flushing 16 bytes that wait out the longest stalls.
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // One step of the directed table: a register write or an input byte. A pinned row carries
  // its own expected output: pin_n copies of pin_byte, tlast on the final one.
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  addr;
    logic [63:0] wdata;
    logic [7:0]  data;
    logic        eom;
    logic        pinned;
    logic [4:0]  pin_n;
    logic [7:0]  pin_byte;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } cipher_byte_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = '0;
  logic [63:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] data_byte
  logic        in_tlast   = 1'b0; // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] out_byte
  logic        out_tlast;         // last_of_block

  // Local copy of the cipher state: registers as written, the block being collected and
  // its fill level. The buffer starts at zero; padding covers every slot above the fill
  // level, so its start value never shows up in a prediction.
  logic [4:0]   shadow_len     = 5'd16;
  logic [63:0]  shadow_table   = '0;
  logic         shadow_decrypt = 1'b0;
  logic [7:0]   shadow_buf [btc_pkg::MaxBlock];
  int unsigned  shadow_fill    = 0;
  logic [7:0]   permuted [btc_pkg::MaxBlock];

  cipher_byte_t pending_bytes [$];
  dir_row_t     dir_rows [$];

  int unsigned  cycle_count = 0;
  int unsigned  error_count = 0;
  int unsigned  in_gap_mode = 0;    // 0 never idles, 1 idles now and then, 2 idles often
  int unsigned  out_stall_mode = 0; // same scale for the receiver
  int unsigned  stall_left = 0;
  int unsigned  stall_roll;

  block_transposition_cipher_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stores one byte in the model and, when the block closes, leaves the permuted block in
  // permuted[] and returns its length. Returns zero while the block is still filling.
  function automatic int permute_block(input logic [7:0] b, input logic eom);
    int unsigned n, j, s;
    n = shadow_len;
    if (n == 0) begin
      n = 1;
    end
    if (n > btc_pkg::MaxBlock) begin
      n = btc_pkg::MaxBlock;
    end
    // A byte beyond a lowered length still lands in the buffer; it is dropped on output.
    if (shadow_fill < btc_pkg::MaxBlock) begin
      shadow_buf[shadow_fill] = b;
      shadow_fill++;
    end
    if (shadow_fill < n && !eom) begin
      return 0;
    end
    for (j = shadow_fill; j < btc_pkg::MaxBlock; j++) begin
      shadow_buf[j] = btc_pkg::PAD_BYTE;
    end
    if (!shadow_decrypt) begin
      // Gather: output j takes stored byte perm[j]. Entries past the length read padding
      // or a dropped byte, whichever the buffer holds there.
      for (j = 0; j < n; j++) begin
        permuted[j] = shadow_buf[shadow_table[4*j +: 4]];
      end
    end else begin
      // Scatter: stored byte j goes to output perm[j]. Positions nobody hits stay spaces,
      // entries past the length are skipped, and on a collision the later entry wins.
      for (j = 0; j < n; j++) begin
        permuted[j] = btc_pkg::PAD_BYTE;
      end
      for (j = 0; j < n; j++) begin
        s = shadow_table[4*j +: 4];
        if (s < n) begin
          permuted[s] = shadow_buf[j];
        end
      end
    end
    shadow_fill = 0;
    return n;
  endfunction

  function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [63:0] value);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.addr = idx;
    r.wdata = value;
    return r;
  endfunction

  function automatic dir_row_t byte_row(input logic [7:0] b, input logic eom);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.data = b;
    r.eom = eom;
    return r;
  endfunction

  function automatic dir_row_t pinned_row(input logic [7:0] b, input logic eom,
                                          input logic [4:0] n, input logic [7:0] value);
    dir_row_t r;
    r = byte_row(b, eom);
    r.pinned = 1'b1;
    r.pin_n = n;
    r.pin_byte = value;
    return r;
  endfunction

  // Appends one row to the end of the directed table.
  task automatic add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Appends one predicted byte to the end of the expected output.
  task automatic expect_byte(input logic [7:0] value, input logic last);
    cipher_byte_t e;
    e.value = value;
    e.last  = last;
    pending_bytes.insert(pending_bytes.size(), e);
  endtask

  task automatic log_error(input string what);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Offers one byte, after an optional idle gap, and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int unsigned roll, gap;
    gap = 0;
    if (in_gap_mode != 0) begin
      roll = $urandom_range(0, 99);
      if (roll < ((in_gap_mode == 1) ? 20 : 55)) begin
        gap = $urandom_range(1, 3);
      end else if (roll < ((in_gap_mode == 1) ? 23 : 62)) begin
        gap = $urandom_range(8, 30);
      end
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eom;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic eom);
    int n;
    send_byte(b, eom);
    n = permute_block(b, eom);
    for (int k = 0; k < n; k++) begin
      expect_byte(permuted[k], k == n - 1);
    end
  endtask

  // Holds the sender off until every predicted byte has left the unit, then a little longer.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen with the unit drained; a partial block may still be held.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      btc_pkg::REG_BLOCK_LENGTH: shadow_len     = value[4:0];
      btc_pkg::REG_PERM_TABLE:   shadow_table   = value;
      btc_pkg::REG_DECRYPT_MODE: shadow_decrypt = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver: always ready in mode 0; otherwise short stalls and the odd long one, per mode.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (out_stall_mode == 0) begin
      out_tready <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < ((out_stall_mode == 1) ? 75 : 35)) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = (stall_roll < 96) ? $urandom_range(0, 2) : $urandom_range(5, 30);
      end
    end
  end

  // Each byte taken from the unit must match the oldest prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_bytes.size() == 0) begin
        log_error($sformatf("unexpected output byte %02h last %0b", out_tdata, out_tlast));
      end else if (out_tdata !== pending_bytes[0].value || out_tlast !== pending_bytes[0].last)
      begin
        log_error($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                            pending_bytes[0].value, pending_bytes[0].last,
                            out_tdata, out_tlast));
        void'(pending_bytes.pop_front());
      end else begin
        void'(pending_bytes.pop_front());
      end
    end
  end

  // Watchdog: a run that has not finished by the limit is a failure.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("block_transposition_cipher_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    dir_row_t     row;
    logic [4:0]   raw_len;
    logic [63:0]  value;
    logic [3:0]   ent [btc_pkg::MaxBlock];
    logic [3:0]   swap;
    logic [7:0]   b;
    int unsigned  eff, j, k, phase, sent, burst, eom_pct;

    for (j = 0; j < btc_pkg::MaxBlock; j++) begin
      shadow_buf[j] = '0;
    end

    // After reset the table is all zeros, so every position of a block repeats stored
    // byte 0; a lone byte with end of message is padded out to the full 16.
    add_row(pinned_row(8'hFF, 1'b1, 5'd16, 8'hFF));
    // A length of zero counts as one. Entry 0 points at slot 15, past the block, and reads padding.
    add_row(cfg_row(btc_pkg::REG_BLOCK_LENGTH, 64'd0));
    add_row(cfg_row(btc_pkg::REG_PERM_TABLE, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(pinned_row(8'h00, 1'b0, 5'd1, btc_pkg::PAD_BYTE));
    // A length above the maximum clamps to 16; decrypt with the identity table.
    add_row(cfg_row(btc_pkg::REG_BLOCK_LENGTH, 64'd31));
    add_row(cfg_row(btc_pkg::REG_PERM_TABLE, 64'hFEDC_BA98_7654_3210));
    add_row(cfg_row(btc_pkg::REG_DECRYPT_MODE, 64'd1));
    add_row(byte_row(8'h00, 1'b0));
    add_row(byte_row(8'hFF, 1'b0));
    add_row(byte_row(8'h80, 1'b1));
    // A write to the unused index must not disturb the length, table or mode.
    add_row(cfg_row(REG_UNUSED, 64'd0));
    add_row(byte_row(8'h5A, 1'b1));
    // Lower the length under a partly filled block: the next byte closes it at three, and
    // entries 4 and 5 read bytes that the shorter block drops.
    add_row(cfg_row(btc_pkg::REG_DECRYPT_MODE, 64'd0));
    add_row(cfg_row(btc_pkg::REG_BLOCK_LENGTH, 64'd16));
    add_row(cfg_row(btc_pkg::REG_PERM_TABLE, 64'h0000_0000_0000_0054));
    add_row(byte_row(8'h11, 1'b0));
    add_row(byte_row(8'h22, 1'b0));
    add_row(byte_row(8'h33, 1'b0));
    add_row(byte_row(8'h44, 1'b0));
    add_row(byte_row(8'h55, 1'b0));
    add_row(cfg_row(btc_pkg::REG_BLOCK_LENGTH, 64'd3));
    add_row(byte_row(8'h66, 1'b0));
    // Decrypt with two entries on position 1, one entry past the block, positions 2 and 3 unhit.
    add_row(cfg_row(btc_pkg::REG_BLOCK_LENGTH, 64'd4));
    add_row(cfg_row(btc_pkg::REG_PERM_TABLE, 64'h0000_0000_0000_0711));
    add_row(cfg_row(btc_pkg::REG_DECRYPT_MODE, 64'd1));
    add_row(byte_row(8'hA1, 1'b0));
    add_row(byte_row(8'hB2, 1'b0));
    add_row(byte_row(8'hC3, 1'b0));
    add_row(byte_row(8'hD4, 1'b0));
    add_row(byte_row(8'hE5, 1'b1));
    // Encrypt where every entry lies past a padded one-byte block: all spaces.
    add_row(cfg_row(btc_pkg::REG_DECRYPT_MODE, 64'd0));
    add_row(cfg_row(btc_pkg::REG_PERM_TABLE, 64'h0000_0000_0000_FEDC));
    add_row(pinned_row(8'h7F, 1'b1, 5'd4, btc_pkg::PAD_BYTE));
    // One-byte blocks pass straight through.
    add_row(cfg_row(btc_pkg::REG_BLOCK_LENGTH, 64'd1));
    add_row(cfg_row(btc_pkg::REG_PERM_TABLE, 64'd0));
    add_row(pinned_row(8'h01, 1'b1, 5'd1, 8'h01));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gap_mode    = 1;
    out_stall_mode = 1;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.addr, row.wdata);
      end else if (row.pinned) begin
        // The model still has to see the byte so its fill level stays in step.
        send_byte(row.data, row.eom);
        void'(permute_block(row.data, row.eom));
        for (k = 0; k < row.pin_n; k++) begin
          expect_byte(row.pin_byte, k == row.pin_n - 1);
        end
      end else begin
        feed_byte(row.data, row.eom);
      end
    end

    // Random phases. Each loads a new length, table and mode, with junk in the unused
    // upper bits of the write data, and then streams a burst of bytes. A burst may stop
    // mid-block, so the next phase can change the length under a partial block.
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 8)
        0:       raw_len = 5'd16;
        1:       raw_len = 5'd1;
        2:       raw_len = 5'd0;
        3:       raw_len = 5'd31;
        4:       raw_len = 5'd17;
        5:       raw_len = 5'($urandom_range(0, 31));
        default: raw_len = 5'($urandom_range(2, 15));
      endcase
      eff = (raw_len == 0) ? 1 : ((raw_len > btc_pkg::MaxBlock) ? btc_pkg::MaxBlock : raw_len);

      // Most often a shuffled permutation of the block, sometimes identity or reversed, and
      // now and then raw random nibbles with collisions and out-of-range entries.
      for (j = 0; j < btc_pkg::MaxBlock; j++) begin
        ent[j] = 4'(j);
      end
      case (phase % 5)
        1: ;
        2: begin
          for (j = 0; j < eff; j++) begin
            ent[j] = 4'(eff - 1 - j);
          end
        end
        3: begin
          for (j = 0; j < btc_pkg::MaxBlock; j++) begin
            ent[j] = 4'($urandom_range(0, 15));
          end
        end
        default: begin
          for (j = eff - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            swap = ent[j];
            ent[j] = ent[k];
            ent[k] = swap;
          end
          for (j = eff; j < btc_pkg::MaxBlock; j++) begin
            ent[j] = 4'($urandom_range(0, 15));
          end
        end
      endcase
      for (j = 0; j < btc_pkg::MaxBlock; j++) begin
        value[4*j +: 4] = ent[j];
      end
      write_reg(btc_pkg::REG_PERM_TABLE, value);

      value = {$urandom, $urandom};
      value[4:0] = raw_len;
      write_reg(btc_pkg::REG_BLOCK_LENGTH, value);
      value = {$urandom, $urandom};
      value[0] = 1'((phase / 2) % 2);
      write_reg(btc_pkg::REG_DECRYPT_MODE, value);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_UNUSED, {$urandom, $urandom});
      end

      in_gap_mode    = (phase == 0) ? 0 : $urandom_range(0, 2);
      out_stall_mode = (phase == 0) ? 0 : $urandom_range(0, 2);
      case ($urandom_range(0, 2))
        0:       eom_pct = 2;
        1:       eom_pct = 12;
        default: eom_pct = 40;
      endcase

      burst = $urandom_range(30, 50);
      for (j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
        case ($urandom_range(0, 9))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        feed_byte(b, $urandom_range(0, 99) < eom_pct);
        sent++;
        // Occasionally the sender waits for the unit to empty before going on.
        if ($urandom_range(0, 59) == 0) begin
          settle();
        end
      end
      phase++;
    end

    // Let everything drain, then watch a while longer for stray output.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      log_error($sformatf("%0d predicted bytes never arrived", pending_bytes.size()));
    end

    if (error_count == 0) begin
      $display("block_transposition_cipher_unit regression: pass");
    end else begin
      $display("block_transposition_cipher_unit regression: fail");
    end
    $finish;
  end

endmodule
